@@ rtl/tcpu_pkg.sv @@
// Shared types, widths and codes for the tiny CPU step unit.
package tcpu_pkg;

  localparam int unsigned MEM_WORDS_DEF = 2048;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned ADDR_W        = 11;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned NREGS         = 4;

  typedef logic [WORD_W-1:0]             word_t;
  typedef logic [NREGS-1:0][WORD_W-1:0]  regfile_t;

  // Item kind carried on the input channel
  typedef enum logic {
    OPN_WRITE = 1'b0,
    OPN_STEP  = 1'b1
  } operation_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_HALT        = 3'd1,
    ST_TRACE       = 3'd2,
    ST_LOAD_FAULT  = 3'd3,
    ST_STORE_FAULT = 3'd4,
    ST_FETCH_FAULT = 3'd5
  } status_t;

  // Instruction opcodes (bits 15..13)
  typedef enum logic [2:0] {
    OPC_ADDSUB = 3'd0,
    OPC_AND    = 3'd1,
    OPC_OR     = 3'd2,
    OPC_SLT    = 3'd3,
    OPC_BRANCH = 3'd4,
    OPC_LDST   = 3'd5,
    OPC_CALL   = 3'd6,
    OPC_SHIFT  = 3'd7
  } opcode_t;

  // Special r2 selectors of the return group
  localparam logic [1:0] R2_TRACE = 2'd1;
  localparam logic [1:0] R2_HALT  = 2'd3;

  // Outcome of executing one fetched word
  typedef struct packed {
    status_t    status;
    word_t      pc;
    logic       reg_we;
    logic [1:0] rd;
    word_t      wdata;
    logic       mem_we;
    logic       mem_rd;
    word_t      ea;
  } exec_res_t;

endpackage

@@ rtl/tcpu_chan_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface tcpu_in_if;
  import tcpu_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [ADDR_W-1:0]   address;
  logic [WORD_W-1:0]   data;

  modport source (output valid, operation, address, data, input ready);
  modport sink   (input valid, operation, address, data, output ready);
endinterface

interface tcpu_out_if;
  import tcpu_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   pc;
  logic [WORD_W-1:0]   reg_a;
  logic [WORD_W-1:0]   reg_b;
  logic [WORD_W-1:0]   reg_c;
  logic [WORD_W-1:0]   reg_d;

  modport source (output valid, status, pc, reg_a, reg_b, reg_c, reg_d, input ready);
  modport sink   (input valid, status, pc, reg_a, reg_b, reg_c, reg_d, output ready);
endinterface

@@ rtl/tcpu_mem.sv @@
// Main memory: one write port, one read port with registered read data.
module tcpu_mem #(
  parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MEM_WORDS)-1:0]  waddr,
  input  tcpu_pkg::word_t               wdata,
  input  logic                          re,
  input  logic [$clog2(MEM_WORDS)-1:0]  raddr,
  output tcpu_pkg::word_t               rdata
);
  import tcpu_pkg::*;

  word_t mem_r [MEM_WORDS];
  word_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port with registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tcpu_exec.sv @@
// Decode and execute of one fetched instruction word.
module tcpu_exec #(
  parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  tcpu_pkg::word_t     instr,
  input  tcpu_pkg::word_t     pc,
  input  tcpu_pkg::regfile_t  regs,
  output tcpu_pkg::exec_res_t res
);
  import tcpu_pkg::*;

  localparam logic [WORD_W:0] MEM_LIMIT = (WORD_W+1)'(MEM_WORDS);

  opcode_t    op;
  logic [1:0] r1;
  logic [1:0] r2;
  logic [7:0] imm;
  logic       vrt;
  word_t      imm_z;
  word_t      imm_s;
  word_t      pc_inc;
  word_t      x;
  word_t      y;
  word_t      ea;
  logic       ea_ok;

  // field split
  assign op     = opcode_t'(instr[15:13]);
  assign r1     = instr[12:11];
  assign r2     = instr[10:9];
  assign imm    = instr[8:1];
  assign vrt    = instr[0];
  assign imm_z  = {8'b0, imm};
  assign imm_s  = {{8{imm[7]}}, imm};
  assign pc_inc = pc + 16'd1;
  assign x      = regs[r1];
  assign y      = regs[r2];
  assign ea     = y + imm_s;
  assign ea_ok  = ({1'b0, ea} < MEM_LIMIT);

  always_comb begin
    res        = '0;
    res.status = ST_OK;
    res.pc     = pc_inc;
    res.rd     = r1;
    res.ea     = ea;
    unique case (op)
      OPC_ADDSUB: begin
        res.reg_we = 1'b1;
        res.wdata  = vrt ? (x - y - imm_z) : (x + y + imm_z);
      end
      OPC_AND: begin
        res.reg_we = 1'b1;
        res.wdata  = vrt ? ~(x & y) : (x & y);
      end
      OPC_OR: begin
        res.reg_we = 1'b1;
        res.wdata  = vrt ? ~(x | y) : (x | y);
      end
      OPC_SLT: begin
        res.reg_we = 1'b1;
        res.wdata  = vrt ? {15'b0, (x > y)} : {15'b0, (x < y)};
      end
      OPC_BRANCH: begin
        if ((x == y) != vrt) begin
          res.pc = pc_inc + imm_s;
        end
      end
      OPC_LDST: begin
        // store data rides on wdata; a load finishes after the data read
        if (!ea_ok) begin
          res.status = vrt ? ST_STORE_FAULT : ST_LOAD_FAULT;
        end else if (vrt) begin
          res.mem_we = 1'b1;
          res.wdata  = x;
        end else begin
          res.mem_rd = 1'b1;
        end
      end
      OPC_CALL: begin
        if (!vrt) begin
          res.reg_we = 1'b1;
          res.wdata  = pc_inc;
          res.pc     = imm_z;
        end else if (r2 == R2_HALT) begin
          res.status = ST_HALT;
        end else if (r2 == R2_TRACE) begin
          res.status = ST_TRACE;
        end else begin
          res.pc = x;
        end
      end
      OPC_SHIFT: begin
        res.reg_we = 1'b1;
        res.wdata  = vrt ? (y >> imm[3:0]) : (y << imm[3:0]);
      end
    endcase
  end

endmodule

@@ rtl/tiny_cpu_instruction_step_unit.sv @@
// Tiny CPU step unit: a 16-bit, four-register CPU executed one instruction per
// step beat, with a word-addressed main memory loaded by write beats. Every input
// beat yields one result beat carrying status, pc and all four registers. After
// reset the memory is cleared by a pass over every word, during which no beat is
// accepted. A memory write, or a step while stopped or faulting on fetch, is
// handled in the idle state; an ordinary step reads the instruction, then executes;
// a load adds a data read, which goes through the same memory read port after the
// instruction read. Results sit in an output register, so a new beat is accepted
// while the previous result still waits to be taken.
module tiny_cpu_instruction_step_unit #(
  parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcpu_in_if.sink     in_chan,
  tcpu_out_if.source  out_chan
);
  import tcpu_pkg::*;

  localparam int unsigned     AW        = $clog2(MEM_WORDS);
  localparam logic [WORD_W:0] MEM_LIMIT = (WORD_W+1)'(MEM_WORDS);
  localparam logic [AW-1:0]   LAST_IDX  = AW'(MEM_WORDS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_LOAD  = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  word_t      pc_r, pc_nxt;
  regfile_t   regs_r, regs_nxt;
  status_t    stop_r, stop_nxt;
  status_t    sts_r, sts_nxt;
  logic [1:0] ld_sel_r, ld_sel_nxt;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_sts_r;
  word_t      out_pc_r;
  regfile_t   out_regs_r;

  logic       in_beat;
  logic       finish;
  logic       slot_free;
  logic       out_load;
  word_t      wr_addr16;
  logic       wr_ok;
  logic       pc_ok;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;
  exec_res_t     ex_res;

  tcpu_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcpu_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
    .instr (mem_rdata),
    .pc    (pc_r),
    .regs  (regs_r),
    .res   (ex_res)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_beat       = in_chan.valid && (state_r == S_IDLE);
  assign wr_addr16     = {{(WORD_W-ADDR_W){1'b0}}, in_chan.address};
  assign wr_ok         = ({1'b0, wr_addr16} < MEM_LIMIT);
  assign pc_ok         = ({1'b0, pc_r} < MEM_LIMIT);
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign out_load      = finish && slot_free;

  // step sequencer: memory clear, write beats, fetch, execute, optional data read, hand-off to output
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    pc_nxt      = pc_r;
    regs_nxt    = regs_r;
    stop_nxt    = stop_r;
    sts_nxt     = sts_r;
    ld_sel_nxt  = ld_sel_r;
    finish      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr16[AW-1:0];
    mem_wdata   = in_chan.data;
    mem_re      = 1'b0;
    mem_raddr   = pc_r[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          if (in_chan.operation == OPN_WRITE) begin
            mem_we  = wr_ok;
            sts_nxt = stop_r;
            finish  = 1'b1;
          end else if (stop_r != ST_OK) begin
            sts_nxt = stop_r;
            finish  = 1'b1;
          end else if (!pc_ok) begin
            sts_nxt  = ST_FETCH_FAULT;
            stop_nxt = ST_FETCH_FAULT;
            finish   = 1'b1;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        pc_nxt = ex_res.pc;
        if (ex_res.reg_we) begin
          regs_nxt[ex_res.rd] = ex_res.wdata;
        end
        mem_we    = ex_res.mem_we;
        mem_waddr = ex_res.ea[AW-1:0];
        mem_wdata = ex_res.wdata;
        mem_raddr = ex_res.ea[AW-1:0];
        if (ex_res.mem_rd) begin
          mem_re     = 1'b1;
          ld_sel_nxt = ex_res.rd;
          state_nxt  = S_LOAD;
        end else begin
          sts_nxt = ex_res.status;
          if (ex_res.status != ST_OK && ex_res.status != ST_TRACE) begin
            stop_nxt = ex_res.status;
          end
          finish = 1'b1;
        end
      end
      S_LOAD: begin
        regs_nxt[ld_sel_r] = mem_rdata;
        sts_nxt            = ST_OK;
        finish             = 1'b1;
      end
      S_PUSH: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result goes out now, or waits in the push state for a free slot
    if (finish) begin
      state_nxt = slot_free ? S_IDLE : S_PUSH;
    end
  end

  // output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      pc_r        <= '0;
      regs_r      <= '0;
      stop_r      <= ST_OK;
      sts_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pc_r        <= pc_nxt;
      regs_r      <= regs_nxt;
      stop_r      <= stop_nxt;
      sts_r       <= sts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_sel_r <= ld_sel_nxt;
    if (out_load) begin
      out_sts_r  <= sts_nxt;
      out_pc_r   <= pc_nxt;
      out_regs_r <= regs_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_sts_r;
  assign out_chan.pc     = out_pc_r;
  assign out_chan.reg_a  = out_regs_r[0];
  assign out_chan.reg_b  = out_regs_r[1];
  assign out_chan.reg_c  = out_regs_r[2];
  assign out_chan.reg_d  = out_regs_r[3];

endmodule
